[rtl/core/snt_pkg.sv]
package snt_pkg;

   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_KEY_WIDTH   = 16;

   localparam int KEY_W   = 16;
   localparam int MEMB_W  = 16;
   localparam int NOISE_W = 16;
   localparam int VALUE_W = 32;

   localparam logic [NOISE_W-1:0] NPU_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_SUM    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_mid;
      logic cmp;
      logic rd_shift;
      logic wr_shift;
      logic wr_new;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   search_open;
      logic   shift_more;
      logic   refuse;
      logic   out_free;
   } dp_status_type;

endpackage

[rtl/core/snt_ctrl.sv]
module snt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  snt_pkg::dp_status_type st,
   output snt_pkg::ctrl_cmd_type  cmd
);
   import snt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: begin
            if (st.search_open) begin
               cmd.rd_mid = 1'b1;
               state_in   = ST_SRCH_CMP;
            end else if (st.op == OP_INSERT && !st.refuse) begin
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SRCH_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = ST_SRCH_RD;
         end
         ST_SHIFT_RD: begin
            if (st.shift_more) begin
               cmd.rd_shift = 1'b1;
               state_in     = ST_SHIFT_WR;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         ST_PLACE: begin
            cmd.wr_new = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (st.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/snt_dpath.sv]
module snt_dpath #(
   parameter int TABLE_DEPTH = snt_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_WIDTH   = snt_pkg::DEF_KEY_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [1:0]                     req_op,
   input  logic [snt_pkg::KEY_W-1:0]      req_key,
   input  logic [snt_pkg::MEMB_W-1:0]     req_memb,
   input  logic                           req_last,
   input  logic [snt_pkg::NOISE_W-1:0]    npu,
   input  snt_pkg::ctrl_cmd_type          cmd,
   output snt_pkg::dp_status_type         st,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [snt_pkg::VALUE_W-1:0]    rsp_value,
   output logic                           rsp_found,
   output logic                           rsp_status,
   output logic                           rsp_full,
   output logic                           rsp_done
);
   import snt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
   localparam int EW = NOISE_W + KW;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   logic [EW-1:0] mem_ff [TABLE_DEPTH];
   logic [EW-1:0] rdata_ff;

   op_type              op_ff, op_in;
   logic [KW-1:0]       key_ff, key_in;
   logic [MEMB_W-1:0]   memb_ff, memb_in;
   logic                last_ff, last_in;
   logic                refuse_ff, refuse_in;
   logic [CW-1:0]       lo_ff, lo_in;
   logic [CW-1:0]       hi_ff, hi_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic                eq_ff, eq_in;
   logic [NOISE_W-1:0]  hit_ff, hit_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       cursor_ff, cursor_in;
   logic [VALUE_W-1:0]  sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_status_ff, rsp_status_in;
   logic                rsp_full_ff, rsp_full_in;
   logic                rsp_done_ff, rsp_done_in;

   logic [CW-1:0]       mid;
   logic [CW-1:0]       idx_m1;
   logic [CW-1:0]       from;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic [EW-1:0]       wr_data;
   logic                wr_en;
   logic [KW-1:0]       rd_id;
   logic [NOISE_W-1:0]  rd_noise;
   logic                upper;
   logic                go_right;
   logic [NOISE_W-1:0]  nz;
   logic                hit_lower;
   logic [VALUE_W-1:0]  sum_new;

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign idx_m1   = idx_ff - CW'(1);
   assign from     = (cursor_ff < count_ff) ? cursor_ff : count_ff;
   assign rd_id    = rdata_ff[KW-1:0];
   assign rd_noise = rdata_ff[EW-1:KW];
   assign upper    = (op_ff == OP_INSERT);
   assign go_right = upper ? (rd_id <= key_ff) : (rd_id < key_ff);
   assign nz       = (memb_ff >= npu) ? '0 : npu - memb_ff;
   assign hit_lower = (lo_ff < count_ff) && eq_ff;
   assign sum_new  = sum_ff + (hit_lower ? {{(VALUE_W-NOISE_W){1'b0}}, hit_ff}
                                         : {{(VALUE_W-NOISE_W){1'b0}}, npu});

   assign rd_addr = cmd.rd_mid ? mid[AW-1:0] : idx_m1[AW-1:0];
   assign wr_en   = cmd.wr_shift || cmd.wr_new;
   assign wr_addr = cmd.wr_shift ? idx_ff[AW-1:0] : lo_ff[AW-1:0];
   assign wr_data = cmd.wr_shift ? rdata_ff : {nz, key_ff};

   always_ff @(posedge clock) begin
      if (cmd.rd_mid || cmd.rd_shift) begin
         rdata_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_comb begin
      op_in         = op_ff;
      key_in        = key_ff;
      memb_in       = memb_ff;
      last_in       = last_ff;
      refuse_in     = refuse_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      idx_in        = idx_ff;
      eq_in         = eq_ff;
      hit_in        = hit_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_done_in   = rsp_done_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load) begin
         op_in     = op_type'(req_op);
         key_in    = req_key[KW-1:0];
         memb_in   = req_memb;
         last_in   = req_last;
         refuse_in = (count_ff == DEPTH_C);
         lo_in     = (op_type'(req_op) == OP_SUM) ? from : '0;
         hi_in     = (op_type'(req_op) == OP_CLEAR) ? '0 : count_ff;
         idx_in    = count_ff;
         eq_in     = 1'b0;
      end

      if (cmd.cmp) begin
         if (go_right) begin
            lo_in = mid + CW'(1);
            if (upper) begin
               eq_in = (rd_id == key_ff);
            end
         end else begin
            hi_in = mid;
            if (!upper) begin
               eq_in  = (rd_id == key_ff);
               hit_in = rd_noise;
            end
         end
      end

      if (cmd.wr_shift) begin
         idx_in = idx_m1;
      end

      if (cmd.wr_new) begin
         count_in = count_ff + CW'(1);
      end

      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_found_in  = 1'b0;
         rsp_status_in = 1'b0;
         rsp_full_in   = (count_ff == DEPTH_C);
         rsp_done_in   = 1'b0;
         case (op_ff)
            OP_CLEAR: begin
               count_in    = '0;
               cursor_in   = '0;
               sum_in      = '0;
               rsp_full_in = 1'b0;
            end
            OP_INSERT: begin
               cursor_in     = '0;
               sum_in        = '0;
               rsp_found_in  = (lo_ff != '0) && eq_ff;
               rsp_status_in = refuse_ff;
               rsp_value_in  = refuse_ff ? '0 : {{(VALUE_W-NOISE_W){1'b0}}, nz};
            end
            OP_LOOKUP: begin
               rsp_found_in = hit_lower;
               rsp_value_in = hit_lower ? {{(VALUE_W-NOISE_W){1'b0}}, hit_ff}
                                        : {{(VALUE_W-NOISE_W){1'b0}}, npu};
            end
            OP_SUM: begin
               rsp_found_in = hit_lower;
               rsp_value_in = sum_new;
               rsp_done_in  = last_ff;
               cursor_in    = last_ff ? '0 : lo_ff;
               sum_in       = last_ff ? '0 : sum_new;
            end
            default: begin
               rsp_value_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      memb_ff       <= memb_in;
      last_ff       <= last_in;
      refuse_ff     <= refuse_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      idx_ff        <= idx_in;
      eq_ff         <= eq_in;
      hit_ff        <= hit_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_full_ff   <= rsp_full_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign st.op          = op_ff;
   assign st.search_open = (lo_ff < hi_ff);
   assign st.shift_more  = (idx_ff > lo_ff);
   assign st.refuse      = refuse_ff;
   assign st.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_full   = rsp_full_ff;
   assign rsp_done   = rsp_done_ff;

endmodule

[rtl/core/sparse_noise_table_lookup_sum.sv]
// The result is registered after a binary search of S probes over the searched span
// (S <= clog2(entries+1); no probes for a clear). An accepted insert then shifts every entry
// above its position up by one through the table memory, reading and writing one entry at a time.
// One item at a time: the next transfer is taken
// in the cycle after the result is registered, and a stalled result holds the item in progress.
// Reset (synchronous, active high) empties the table, zeroes cursor and sum and sets
// noise_per_unit to 65535; table memory contents are not cleared.
module sparse_noise_table_lookup_sum #(
   parameter int TABLE_DEPTH = snt_pkg::DEF_TABLE_DEPTH,
   parameter int KEY_WIDTH   = snt_pkg::DEF_KEY_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key [15:0], membership [31:16]
   input  logic [1:0]  req_tuser,   // operation [1:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value [31:0]
   output logic [2:0]  rsp_tuser,   // found [0], status [1], table_full [2]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import snt_pkg::*;

   logic [NOISE_W-1:0] npu_ff, npu_in;
   ctrl_cmd_type       cmd;
   dp_status_type      st;

   assign csr_ready = 1'b1;
   assign npu_in    = (csr_valid && csr_ready) ? csr_data : npu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         npu_ff <= NPU_RESET;
      end else begin
         npu_ff <= npu_in;
      end
   end

   snt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   snt_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_op     (req_tuser),
      .req_key    (req_tdata[15:0]),
      .req_memb   (req_tdata[31:16]),
      .req_last   (req_tlast),
      .npu        (npu_ff),
      .cmd        (cmd),
      .st         (st),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_value  (rsp_tdata),
      .rsp_found  (rsp_tuser[0]),
      .rsp_status (rsp_tuser[1]),
      .rsp_full   (rsp_tuser[2]),
      .rsp_done   (rsp_tlast)
   );

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while an item is in progress");

   a_refuse_only_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[2])
      else $error("insert refused while table not full");

   a_done_not_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_tuser[1])
      else $error("sum completion flagged with refusal");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("controller issued more than one command");

endmodule

[test/sparse_noise_table_lookup_sum_test.sv]
module sparse_noise_table_lookup_sum_test;
   import snt_pkg::*;

   localparam int TBL_DEPTH  = DEF_TABLE_DEPTH;
   localparam int HANG_LIMIT = 20000;

   typedef struct packed {
      logic [31:0] value;
      logic        found;
      logic        refused;
      logic        full;
      logic        done;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // key [15:0], membership [31:16]
   logic [1:0]  req_tuser;   // operation [1:0]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;   // value [31:0]
   logic [2:0]  rsp_tuser;   // found [0], status [1], table_full [2]
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   // table model
   logic [15:0] npu;
   logic [15:0] tbl_id [TBL_DEPTH];
   logic [15:0] tbl_noise [TBL_DEPTH];
   int          entry_total;
   int          cursor;
   logic [31:0] run_total;

   outcome_type noise_answers [$];
   int          mismatches;
   int          items_sent;
   int          quiet_cycles;
   logic        calm;
   logic [15:0] key_lo;
   logic [15:0] key_span;

   sparse_noise_table_lookup_sum #(
      .TABLE_DEPTH (TBL_DEPTH),
      .KEY_WIDTH   (DEF_KEY_WIDTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 6);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", HANG_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic outcome_type noise_table_step(op_type op, logic [15:0] key,
                                                    logic [15:0] memb, logic last);
      outcome_type o;
      int          p;
      logic [15:0] nz;
      o = '0;
      case (op)
         OP_CLEAR: begin
            entry_total = 0;
            cursor      = 0;
            run_total   = 0;
         end
         OP_INSERT: begin
            cursor    = 0;
            run_total = 0;
            p = 0;
            while (p < entry_total && tbl_id[p] < key) p++;
            o.found = (p < entry_total && tbl_id[p] == key);
            if (entry_total >= TBL_DEPTH) begin
               o.refused = 1'b1;
            end else begin
               nz = (memb >= npu) ? 16'd0 : npu - memb;
               while (p < entry_total && tbl_id[p] <= key) p++;
               for (int i = entry_total; i > p; i--) begin
                  tbl_id[i]    = tbl_id[i-1];
                  tbl_noise[i] = tbl_noise[i-1];
               end
               tbl_id[p]    = key;
               tbl_noise[p] = nz;
               entry_total++;
               o.value = {16'd0, nz};
            end
         end
         OP_LOOKUP: begin
            p = 0;
            while (p < entry_total && tbl_id[p] < key) p++;
            if (p < entry_total && tbl_id[p] == key) begin
               o.found = 1'b1;
               o.value = {16'd0, tbl_noise[p]};
            end else begin
               o.value = {16'd0, npu};
            end
         end
         default: begin
            p = (cursor < entry_total) ? cursor : entry_total;
            while (p < entry_total && tbl_id[p] < key) p++;
            cursor = p;
            if (p < entry_total && tbl_id[p] == key) begin
               o.found   = 1'b1;
               run_total = run_total + {16'd0, tbl_noise[p]};
            end else begin
               run_total = run_total + {16'd0, npu};
            end
            o.value = run_total;
            if (last) begin
               o.done    = 1'b1;
               cursor    = 0;
               run_total = 0;
            end
         end
      endcase
      o.full = (entry_total == TBL_DEPTH);
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata, rsp_tuser[0], rsp_tuser[1], rsp_tuser[2], rsp_tlast};
         if (noise_answers.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected result: value %h found %b status %b full %b sum_done %b",
                        got.value, got.found, got.refused, got.full, got.done);
            end
            mismatches++;
         end else begin
            want = noise_answers.pop_front();
            if (got !== want) begin
               if (mismatches < 10) begin
                  $display("mismatch: expected value %h found %b status %b full %b sum_done %b",
                           want.value, want.found, want.refused, want.full, want.done);
                  $display("          actual   value %h found %b status %b full %b sum_done %b",
                           got.value, got.found, got.refused, got.full, got.done);
               end
               mismatches++;
            end
         end
      end
   end

   task automatic push_item(input op_type op, input logic [15:0] key,
                            input logic [15:0] memb, input logic last);
      if (!calm && $urandom_range(0, 99) < 6) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {memb, key};
      req_tuser  <= op;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      noise_answers.push_back(noise_table_step(op, key, memb, last));
      items_sent++;
   endtask

   task automatic drain_answers();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (noise_answers.size() != 0);
   endtask

   task automatic set_noise_per_unit(input logic [15:0] v);
      drain_answers();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      npu = v;
   endtask

   function automatic logic [15:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55 && entry_total > 0) return tbl_id[$urandom_range(0, entry_total - 1)];
      if (r < 85) return key_lo + 16'($urandom_range(0, key_span));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] pick_membership();
      case ($urandom_range(0, 9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'(npu + $urandom_range(0, 4) - 2);
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic test_directed();
      push_item(OP_LOOKUP, 16'h0000, 16'h1111, 1'b0);
      push_item(OP_SUM,    16'hFFFF, 16'h0000, 1'b1);
      push_item(OP_INSERT, 16'h8000, 16'h0000, 1'b1);
      push_item(OP_INSERT, 16'h8000, 16'h0064, 1'b0);   // duplicate id, lands after
      push_item(OP_LOOKUP, 16'h8000, 16'hFFFF, 1'b1);
      push_item(OP_INSERT, 16'h0000, 16'hFFFF, 1'b0);
      push_item(OP_INSERT, 16'hFFFF, 16'h04D2, 1'b0);
      push_item(OP_INSERT, 16'h1234, 16'hABCD, 1'b0);
      push_item(OP_SUM,    16'h0000, 16'h5555, 1'b0);
      push_item(OP_SUM,    16'h1234, 16'hAAAA, 1'b0);
      push_item(OP_SUM,    16'h8000, 16'h0000, 1'b0);
      push_item(OP_SUM,    16'hFFFF, 16'h0000, 1'b1);
      // descending ids in one run, lookup in the middle
      push_item(OP_SUM,    16'h8000, 16'h0000, 1'b0);
      push_item(OP_SUM,    16'h1234, 16'h0000, 1'b0);
      push_item(OP_LOOKUP, 16'h1234, 16'h0000, 1'b1);
      push_item(OP_SUM,    16'hFFFF, 16'h0000, 1'b1);
      // run broken by an insert
      push_item(OP_SUM,    16'h1234, 16'h0000, 1'b0);
      push_item(OP_INSERT, 16'h4000, 16'h0FFF, 1'b0);
      push_item(OP_SUM,    16'h8000, 16'h0000, 1'b1);
      // run broken by a clear
      push_item(OP_SUM,    16'h0000, 16'h0000, 1'b0);
      push_item(OP_CLEAR,  16'hFFFF, 16'hFFFF, 1'b1);
      push_item(OP_SUM,    16'h0000, 16'h0000, 1'b1);
      push_item(OP_LOOKUP, 16'h8000, 16'h0000, 1'b0);
   endtask

   task automatic test_noise_register();
      logic [15:0] v;
      for (int n = 0; n < 4; n++) begin
         case (n)
            0:       v = 16'd1;
            1:       v = 16'd0;
            2:       v = 16'($urandom_range(2, 65534));
            default: v = 16'hFFFF;
         endcase
         set_noise_per_unit(v);
         push_item(OP_CLEAR,  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0);
         push_item(OP_INSERT, 16'h0100, v, 1'b0);
         push_item(OP_INSERT, 16'h0200, v - 16'd1, 1'b0);
         push_item(OP_INSERT, 16'h0300, 16'hFFFF, 1'b0);
         push_item(OP_INSERT, 16'h0050, 16'h0000, 1'b0);
         push_item(OP_LOOKUP, 16'h0200, 16'h0000, 1'b0);
         push_item(OP_LOOKUP, 16'h7777, 16'h0000, 1'b0);
         push_item(OP_SUM,    16'h0050, 16'h0000, 1'b0);
         push_item(OP_SUM,    16'h0250, 16'h0000, 1'b0);
         push_item(OP_SUM,    16'h0300, 16'h0000, 1'b1);
      end
   endtask

   task automatic test_full_table();
      logic [15:0] k;
      set_noise_per_unit(16'($urandom_range(1, 65535)));
      push_item(OP_CLEAR, 16'h0000, 16'h0000, 1'b0);
      k = 16'd1;
      repeat (TBL_DEPTH - 1) begin
         push_item(OP_INSERT, k, pick_membership(), 1'($urandom_range(0, 1)));
         k = k + 16'($urandom_range(0, 200));
      end
      // front insert shifts every entry and fills the table
      push_item(OP_INSERT, 16'h0000, 16'h0000, 1'b0);
      push_item(OP_INSERT, 16'h0000, 16'h1234, 1'b0);
      push_item(OP_INSERT, 16'hFFFF, 16'h0000, 1'b1);
      push_item(OP_LOOKUP, tbl_id[100], 16'h0000, 1'b0);
      push_item(OP_LOOKUP, 16'hFFFF, 16'h0000, 1'b0);
      push_item(OP_SUM,    tbl_id[3], 16'h0000, 1'b0);
      push_item(OP_SUM,    tbl_id[200], 16'h0000, 1'b0);
      push_item(OP_SUM,    16'hFFFF, 16'h0000, 1'b1);
      push_item(OP_SUM,    tbl_id[TBL_DEPTH - 1], 16'h0000, 1'b1);
      push_item(OP_CLEAR,  16'h0000, 16'h0000, 1'b0);
   endtask

   task automatic test_random_mix();
      int          start;
      int          len;
      int          pick;
      int          j;
      logic [15:0] k;
      logic [15:0] run_keys [12];
      start = items_sent;
      calm  = 1'b1;
      while (items_sent - start < 1650) begin
         if (items_sent - start >= 300) calm = 1'b0;
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 4))
               0:       set_noise_per_unit(16'd1);
               1:       set_noise_per_unit(16'd0);
               2:       set_noise_per_unit(16'hFFFF);
               3:       set_noise_per_unit(16'($urandom_range(1, 16)));
               default: set_noise_per_unit(16'($urandom_range(0, 65535)));
            endcase
         end
         if (entry_total > 200 || $urandom_range(0, 2) == 0) begin
            push_item(OP_CLEAR, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)));
         end
         key_lo = 16'($urandom_range(0, 65535));
         case ($urandom_range(0, 2))
            0:       key_span = 16'd15;
            1:       key_span = 16'd255;
            default: key_span = 16'hFFFF;
         endcase
         repeat ($urandom_range(0, 24)) begin
            push_item(OP_INSERT, pick_key(), pick_membership(), 1'($urandom_range(0, 1)));
         end
         repeat ($urandom_range(2, 10)) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               len = $urandom_range(1, 12);
               for (int i = 0; i < len; i++) begin
                  k = pick_key();
                  j = i;
                  while (j > 0 && run_keys[j-1] > k) begin
                     run_keys[j] = run_keys[j-1];
                     j--;
                  end
                  run_keys[j] = k;
               end
               for (int i = 0; i < len; i++) begin
                  push_item(OP_SUM, run_keys[i], 16'($urandom_range(0, 65535)), i == len - 1);
               end
            end else if (pick < 65) begin
               // unordered ids, stray ends, interruptions
               repeat ($urandom_range(1, 8)) begin
                  case ($urandom_range(0, 5))
                     0:       push_item(OP_LOOKUP, pick_key(), pick_membership(), 1'b1);
                     1:       push_item(OP_INSERT, pick_key(), pick_membership(), 1'b0);
                     default: push_item(OP_SUM, pick_key(), pick_membership(),
                                        $urandom_range(0, 3) == 0);
                  endcase
               end
            end else if (pick < 85) begin
               push_item(OP_LOOKUP, pick_key(), pick_membership(), 1'($urandom_range(0, 1)));
            end else if (pick < 96) begin
               push_item(OP_INSERT, pick_key(), pick_membership(), 1'($urandom_range(0, 1)));
            end else begin
               push_item(OP_CLEAR, pick_key(), pick_membership(), 1'($urandom_range(0, 1)));
            end
         end
      end
      calm = 1'b0;
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_CLEAR;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      calm         = 1'b0;
      mismatches   = 0;
      items_sent   = 0;
      quiet_cycles = 0;
      key_lo       = '0;
      key_span     = 16'd255;
      npu          = NPU_RESET;
      entry_total  = 0;
      cursor       = 0;
      run_total    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_noise_register();
      test_full_table();
      test_random_mix();

      drain_answers();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && noise_answers.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[sparse_noise_table_lookup_sum.f]
rtl/core/snt_pkg.sv
rtl/core/snt_ctrl.sv
rtl/core/snt_dpath.sv
rtl/core/sparse_noise_table_lookup_sum.sv
test/sparse_noise_table_lookup_sum_test.sv
